>>> design/sha256_pkg.sv
// sha-256 package: state codes, round constants and the round functions
// used by the stream hasher and its port checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    localparam int unsigned WORDS      = 8;
    localparam int unsigned LAST_INDEX = WORDS - 1;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [6:0]  LEN_START  = 7'd56;
    localparam logic [6:0]  FULL_BLOCK = 7'd64;

    typedef logic [31:0] t_word;

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word h;
        case (idx)
            3'd0:    h = 32'h6a09e667;
            3'd1:    h = 32'hbb67ae85;
            3'd2:    h = 32'h3c6ef372;
            3'd3:    h = 32'ha54ff53a;
            3'd4:    h = 32'h510e527f;
            3'd5:    h = 32'h9b05688c;
            3'd6:    h = 32'h1f83d9ab;
            3'd7:    h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic t_word round_const(input logic [5:0] t);
        t_word k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // schedule word from buffered bytes, padding byte and length field
    function automatic t_word build_word(
        input logic [3:0]  widx,
        input t_word       raw,
        input logic [6:0]  limit,
        input logic        put_pad,
        input logic        put_len,
        input logic [63:0] bits
    );
        t_word      w;
        logic [6:0] p;
        for (int l = 0; l < 4; l++) begin
            p = {1'b0, widx, 2'(l)};
            if (p < limit) begin
                w[8*(3-l) +: 8] = raw[8*(3-l) +: 8];
            end else if (p == limit && put_pad) begin
                w[8*(3-l) +: 8] = PAD_BYTE;
            end else begin
                w[8*(3-l) +: 8] = 8'h00;
            end
        end
        if (put_len && widx == 4'd14) begin
            w = bits[63:32];
        end else if (put_len && widx == 4'd15) begin
            w = bits[31:0];
        end
        return w;
    endfunction

endpackage
`default_nettype wire

>>> design/sha256_stream_hasher.sv
// sha-256 stream hasher: byte items into a 16-word block memory, 64-round
// compression with a 16-word schedule window, digest out as eight items
// depends on sha256_pkg
// a byte that does not fill the block leaves the hasher idle and ready for more
// a full block passes the load, round and fold states before new items are taken
// end of message: one or two padding blocks, then 8 output items
// synchronous active-low reset restores the initial hash and empty counts
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_message,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    sha256_pkg::t_state r_state;
    sha256_pkg::t_word  r_mem [16];
    sha256_pkg::t_word  r_rd_data;
    sha256_pkg::t_word  r_h [8];
    sha256_pkg::t_word  r_v [8];
    sha256_pkg::t_word  r_w [16];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [4:0]  r_ld;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oidx;
    logic [6:0]  r_limit;
    logic        r_put_pad;
    logic        r_put_len;
    logic        r_more;
    logic        r_pend_pad;
    logic        r_fin;

    logic        acc_in;
    logic        acc_out;
    logic [5:0]  fill_inc;
    sha256_pkg::t_word ld_word;
    sha256_pkg::t_word t1;
    sha256_pkg::t_word t2;
    sha256_pkg::t_word w_new;

    assign o_in_ready    = (r_state == sha256_pkg::ST_IDLE);
    assign o_out_valid   = (r_state == sha256_pkg::ST_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'(sha256_pkg::LAST_INDEX));

    assign acc_in   = i_in_valid && o_in_ready;
    assign acc_out  = o_out_valid && i_out_ready;
    assign fill_inc = r_fill + 6'd1;

    assign ld_word = sha256_pkg::build_word(r_ld[3:0] - 4'd1, r_rd_data, r_limit,
                                            r_put_pad, r_put_len, r_bits);
    assign t1 = r_v[7] + sha256_pkg::big_sigma1(r_v[4])
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha256_pkg::round_const(r_rnd) + r_w[0];
    assign t2 = sha256_pkg::big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new = sha256_pkg::small_sigma1(r_w[14]) + r_w[9]
                 + sha256_pkg::small_sigma0(r_w[1]) + r_w[0];

    // block memory: byte-lane writes, registered word reads
    always_ff @(posedge i_clk) begin
        if (acc_in && i_byte_present) begin
            r_mem[r_fill[5:2]][8*(3-r_fill[1:0]) +: 8] <= i_data_byte;
        end
        r_rd_data <= r_mem[r_ld[3:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sha256_pkg::ST_LOAD && r_ld != 5'd0) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= ld_word;
        end else if (r_state == sha256_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end
        if (r_state == sha256_pkg::ST_LOAD && r_ld == 5'd16) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (r_state == sha256_pkg::ST_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha256_pkg::ST_IDLE;
            r_fill     <= 6'd0;
            r_bits     <= 64'd0;
            r_ld       <= 5'd0;
            r_rnd      <= 6'd0;
            r_oidx     <= 3'd0;
            r_limit    <= 7'd0;
            r_put_pad  <= 1'b0;
            r_put_len  <= 1'b0;
            r_more     <= 1'b0;
            r_pend_pad <= 1'b0;
            r_fin      <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha256_pkg::init_hash(3'(i));
            end
        end else begin
            case (r_state)
                sha256_pkg::ST_IDLE: begin
                    if (acc_in) begin
                        r_ld <= 5'd0;
                        if (i_byte_present) begin
                            r_fill <= fill_inc;
                            r_bits <= r_bits + 64'd8;
                        end
                        r_fin <= i_end_of_message;
                        if (i_byte_present && fill_inc == 6'd0) begin
                            r_limit    <= sha256_pkg::FULL_BLOCK;
                            r_put_pad  <= 1'b0;
                            r_put_len  <= 1'b0;
                            r_more     <= 1'b0;
                            r_pend_pad <= i_end_of_message;
                            r_state    <= sha256_pkg::ST_LOAD;
                        end else if (i_end_of_message) begin
                            r_limit    <= {1'b0, (i_byte_present ? fill_inc : r_fill)};
                            r_put_pad  <= 1'b1;
                            r_put_len  <= ({1'b0, (i_byte_present ? fill_inc : r_fill)}
                                           < sha256_pkg::LEN_START);
                            r_more     <= ({1'b0, (i_byte_present ? fill_inc : r_fill)}
                                           >= sha256_pkg::LEN_START);
                            r_pend_pad <= 1'b0;
                            r_state    <= sha256_pkg::ST_LOAD;
                        end
                    end
                end
                sha256_pkg::ST_LOAD: begin
                    r_ld <= r_ld + 5'd1;
                    if (r_ld == 5'd16) begin
                        r_rnd   <= 6'd0;
                        r_state <= sha256_pkg::ST_ROUND;
                    end
                end
                sha256_pkg::ST_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state <= sha256_pkg::ST_FOLD;
                    end
                end
                sha256_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_ld <= 5'd0;
                    if (r_pend_pad) begin
                        // block filled by the last byte, padding block follows
                        r_limit    <= 7'd0;
                        r_put_pad  <= 1'b1;
                        r_put_len  <= 1'b1;
                        r_more     <= 1'b0;
                        r_pend_pad <= 1'b0;
                        r_state    <= sha256_pkg::ST_LOAD;
                    end else if (r_more) begin
                        r_limit   <= 7'd0;
                        r_put_pad <= 1'b0;
                        r_put_len <= 1'b1;
                        r_more    <= 1'b0;
                        r_state   <= sha256_pkg::ST_LOAD;
                    end else if (r_fin) begin
                        r_oidx  <= 3'd0;
                        r_state <= sha256_pkg::ST_OUT;
                    end else begin
                        r_state <= sha256_pkg::ST_IDLE;
                    end
                end
                sha256_pkg::ST_OUT: begin
                    if (acc_out) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (o_last_word) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= sha256_pkg::init_hash(3'(i));
                            end
                            r_fill  <= 6'd0;
                            r_bits  <= 64'd0;
                            r_fin   <= 1'b0;
                            r_state <= sha256_pkg::ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= sha256_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/sha256_stream_hasher_checker.sv
// port checker for the sha-256 stream hasher and its bind statement
// depends on sha256_pkg and sha256_stream_hasher
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_digest_word,
    input wire logic [2:0]  o_word_index,
    input wire logic        o_last_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_digest_word)
            && $stable(o_word_index))
        else $error("digest item changed while stalled");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_word |=>
            o_out_valid && o_word_index == $past(o_word_index) + 3'd1)
        else $error("digest words not in sequence");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_last_word == (o_word_index == 3'(sha256_pkg::LAST_INDEX)))
        else $error("last word flag mismatch");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while digest pending");

endmodule

bind sha256_stream_hasher sha256_stream_hasher_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
`default_nettype wire

>>> tb/sv/tb.sv
// testbench for sha256_stream_hasher: drives byte items with random gaps and
// output stalls, predicts each digest with its own sha-256 and checks words
// depends on design/sha256_pkg.sv and design/sha256_stream_hasher.sv
`timescale 1ns / 1ps

class digest_board;
    bit [31:0] hw[8];
    bit [7:0]  blk[64];
    int        fill;
    bit [63:0] nbits;
    bit [31:0] exp_word[$];
    bit [2:0]  exp_idx[$];
    bit        exp_last[$];
    int        errors;
    int        words_seen;
    int        digests;

    function new();
        errors = 0;
        words_seen = 0;
        digests = 0;
        restart();
    endfunction

    function void restart();
        hw = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        fill = 0;
        nbits = 0;
    endfunction

    function bit [31:0] ror(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function bit [31:0] kconst(int t);
        bit [31:0] k[64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    function void compress();
        bit [31:0] w[64];
        bit [31:0] v[8];
        bit [31:0] t1, t2, e, a;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        v = hw;
        for (int t = 0; t < 64; t++) begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
               + ((e & v[5]) ^ (~e & v[6])) + kconst(t) + w[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++)
            hw[t] += v[t];
    endfunction

    function void note_item(bit [7:0] b, bit present, bit eom);
        int pos;
        if (present) begin
            blk[fill] = b;
            nbits += 8;
            fill = (fill + 1) % 64;
            if (fill == 0)
                compress();
        end
        if (!eom)
            return;
        pos = fill;
        blk[pos++] = 8'h80;
        if (pos > 56) begin
            while (pos < 64)
                blk[pos++] = 0;
            compress();
            pos = 0;
        end
        while (pos < 56)
            blk[pos++] = 0;
        for (int k = 0; k < 8; k++)
            blk[56+k] = nbits[63-8*k -: 8];
        compress();
        for (int k = 0; k < 8; k++) begin
            exp_word.push_back(hw[k]);
            exp_idx.push_back(3'(k));
            exp_last.push_back(k == 7);
        end
        digests++;
        restart();
    endfunction

    function void check_word(bit [31:0] w, bit [2:0] idx, bit last);
        bit [31:0] ew;
        bit [2:0]  ei;
        bit        el;
        words_seen++;
        if (exp_word.size() == 0) begin
            $display("%0t: unexpected word %h idx %0d last %0b", $time, w, idx, last);
            errors++;
            return;
        end
        ew = exp_word.pop_front();
        ei = exp_idx.pop_front();
        el = exp_last.pop_front();
        if (w !== ew) begin
            $display("%0t: digest_word exp %h got %h", $time, ew, w);
            errors++;
        end
        if (idx !== ei) begin
            $display("%0t: word_index exp %0d got %0d", $time, ei, idx);
            errors++;
        end
        if (last !== el) begin
            $display("%0t: last_word exp %0b got %0b", $time, el, last);
            errors++;
        end
    endfunction

    function int pending();
        return exp_word.size();
    endfunction
endclass

module tb;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        eom;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_board board;
    int          stall_cycles;
    int          items_sent;
    bit          rand_stall;

    sha256_stream_hasher u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_data_byte     (data_byte),
        .i_byte_present  (byte_present),
        .i_end_of_message(eom),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_digest_word   (digest_word),
        .o_word_index    (word_index),
        .o_last_word     (last_word)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // valid stays up between back-to-back items, drops only over a gap
    task automatic send_item(bit [7:0] b, bit present, bit last, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        byte_present <= present;
        eom          <= last;
        do @(posedge clk); while (!in_ready);
        board.note_item(b, present, last);
        items_sent++;
    endtask

    task automatic send_message(int len, bit rand_gap);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom), 1'b1, i == len - 1,
                      rand_gap ? $urandom_range(0, 12) : 0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // output side: accept and check on the edge, then draw the next stall
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            board.check_word(digest_word, word_index, last_word);
            stall_cycles = rand_stall ? $urandom_range(0, 12) : 0;
            if (stall_cycles != 0)
                out_ready <= 1'b0;
        end else if (rst_n && !out_ready) begin
            if (stall_cycles > 0)
                stall_cycles--;
            if (stall_cycles == 0)
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no accepted item on either side
    int idle_count;
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > 5000) begin
            $display("FAIL sha256_stream_hasher");
            $finish;
        end
    end

    initial begin
        int len;
        board        = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        byte_present = 1'b0;
        eom          = 1'b0;
        out_ready    = 1'b1;
        stall_cycles = 0;
        items_sent   = 0;
        rand_stall   = 1'b1;
        idle_count   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, idle items, extremes, padding boundaries
        send_item(8'hff, 1'b0, 1'b1, 0);
        send_item(8'hff, 1'b0, 1'b0, 0);
        send_item(8'h00, 1'b1, 1'b0, 0);
        send_item(8'h5a, 1'b0, 1'b0, 1);
        send_item(8'hff, 1'b1, 1'b1, 0);
        send_item(8'ha5, 1'b1, 1'b0, 0);
        send_item(8'h00, 1'b0, 1'b1, 2);
        drain();
        send_message(56, 1'b0);
        send_message(64, 1'b0);
        drain();
        repeat (200) @(posedge clk);

        while (items_sent < 135) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 3);
                default: len = $urandom_range(1, 12);
            endcase
            if (len == 0)
                send_item(8'($urandom), 1'b0, 1'b1, $urandom_range(0, 12));
            else
                send_message(len, 1'b1);
            if ($urandom_range(0, 7) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, $urandom_range(0, 12));
            if ($urandom_range(0, 5) == 0)
                drain();
        end
        // a trailing byte item without end, then an ending item carrying no byte
        send_item(8'($urandom), 1'b1, 1'b0, 3);
        send_item(8'($urandom), 1'b0, 1'b1, 0);

        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d input items, %0d digests, %0d words checked",
                 items_sent, board.digests, board.words_seen);
        $display("includes empty messages, idle items and 56/64 byte padding edges");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS sha256_stream_hasher");
        end else begin
            $display("FAIL sha256_stream_hasher");
        end
        $finish;
    end
endmodule

>>> files.f
design/sha256_pkg.sv
design/sha256_stream_hasher.sv
design/sha256_stream_hasher_checker.sv
tb/sv/tb.sv
